[rtl/msb_bit_reader_with_unstuffing_defines.svh]
// Assertion macros used by the bit reader top level.
// Depends on nothing; included by the top level, which carries the assertions.
`ifndef MSB_BIT_READER_WITH_UNSTUFFING_DEFINES_SVH
`define MSB_BIT_READER_WITH_UNSTUFFING_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define MSBR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("msbr assertion failed");
// Check that a condition in one cycle implies another in the next.
`define MSBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msbr assertion failed");
`else
`define MSBR_ASSERT(lbl, clk, rst_n, prop)
`define MSBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/msbr_pkg.sv]
// Types and constants for the MSB-first bit reader with byte unstuffing.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package msbr_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_READ = 2'd1,
        REQ_SKIP = 2'd2
    } t_req;

    localparam logic [7:0] STUFF_MARK = 8'hFF;
    localparam logic [7:0] STUFF_ZERO = 8'h00;
    localparam logic [5:0] READ_MAX   = 6'd32;
    localparam int         BYTE_BITS  = 8;

    typedef struct packed {
        logic       unstuff;
        logic [5:0] bit_count;
        logic [7:0] data_byte;
        t_req       req_type;
    } t_item;

    typedef struct packed {
        logic [7:0] prev_byte;
        logic       skip_active;
        logic [7:0] skip_target;
    } t_ctrl;

    // Packed so that read_value lands in the lowest bits
    typedef struct packed {
        logic        skipping;
        logic        overflow;
        logic        byte_dropped;
        logic [6:0]  fill_level;
        logic [5:0]  bits_delivered;
        logic [31:0] read_value;
    } t_result;

endpackage

[rtl/msbr_datapath.sv]
// Single-pass step logic: push, read and skip on the bit buffer.
// Depends on msbr_pkg.
`timescale 1ns / 1ps
module msbr_datapath #(
    parameter int STORE_BITS = 64,
    parameter int FILL_W     = $clog2(STORE_BITS + 1)
) (
    input  msbr_pkg::t_item   i_item,
    input  logic [STORE_BITS-1:0] i_store,
    input  logic [FILL_W-1:0] i_fill,
    input  msbr_pkg::t_ctrl   i_ctrl,
    output logic [STORE_BITS-1:0] o_store,
    output logic [FILL_W-1:0] o_fill,
    output msbr_pkg::t_ctrl   o_ctrl,
    output msbr_pkg::t_result o_res
);
    import msbr_pkg::*;

    localparam logic [FILL_W-1:0] FULL_LIM = FILL_W'(STORE_BITS - BYTE_BITS);

    logic [FILL_W-1:0]     cnt;
    logic                  enough;
    logic [FILL_W-1:0]     rem;
    logic [FILL_W-1:0]     short_gap;
    logic [STORE_BITS-1:0] front;
    logic [STORE_BITS-1:0] keep_mask;
    logic                  take;

    // Clamp the request to 32 bits
    assign cnt       = (i_item.bit_count > READ_MAX) ? FILL_W'(READ_MAX)
                                                     : FILL_W'(i_item.bit_count);
    assign enough    = (cnt <= i_fill);
    assign rem       = i_fill - cnt;
    assign short_gap = cnt - i_fill;
    assign front     = i_store >> rem;
    assign keep_mask = ~({STORE_BITS{1'b1}} << rem);
    assign take      = !i_ctrl.skip_active || (i_item.data_byte == i_ctrl.skip_target);

    always_comb begin
        o_store = i_store;
        o_fill  = i_fill;
        o_ctrl  = i_ctrl;
        o_res   = '0;
        unique case (i_item.req_type)
            REQ_PUSH: begin
                if (i_ctrl.skip_active && take) begin
                    o_ctrl.skip_active = 1'b0;
                end
                if (!take) begin
                    o_res.byte_dropped = 1'b1;
                end else if (i_item.unstuff && (i_ctrl.prev_byte == STUFF_MARK)
                             && (i_item.data_byte == STUFF_ZERO)) begin
                    o_res.byte_dropped = 1'b1;
                    o_ctrl.prev_byte   = STUFF_ZERO;
                end else if (i_fill > FULL_LIM) begin
                    o_res.byte_dropped = 1'b1;
                    o_res.overflow     = 1'b1;
                end else begin
                    o_store          = {i_store[STORE_BITS-BYTE_BITS-1:0], i_item.data_byte};
                    o_fill           = i_fill + FILL_W'(BYTE_BITS);
                    o_ctrl.prev_byte = i_item.data_byte;
                end
            end
            REQ_READ: begin
                if (enough) begin
                    o_res.read_value     = front[31:0];
                    o_res.bits_delivered = cnt[5:0];
                    o_fill               = rem;
                    o_store              = i_store & keep_mask;
                end else begin
                    // Short read: pad the held bits on the right
                    o_res.read_value     = i_store[31:0] << short_gap[5:0];
                    o_res.bits_delivered = i_fill[5:0];
                    o_fill               = '0;
                    o_store              = '0;
                end
            end
            REQ_SKIP: begin
                o_store            = '0;
                o_fill             = '0;
                o_ctrl.skip_active = 1'b1;
                o_ctrl.skip_target = i_item.data_byte;
            end
            default: begin
            end
        endcase
        o_res.fill_level = 7'(o_fill);
        o_res.skipping   = o_ctrl.skip_active;
    end

endmodule

[rtl/msbr_out_reg.sv]
// Result register between the step logic and the output stream.
// Depends on msbr_pkg.
`timescale 1ns / 1ps
module msbr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  msbr_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output msbr_pkg::t_result o_res,
    input  logic              i_ready
);
    import msbr_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_ready;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/msb_bit_reader_with_unstuffing.sv]
// Top level of the MSB-first bit reader with byte unstuffing.
// Depends on msbr_pkg, msbr_datapath, msbr_out_reg and the assertion macro header.
//
//  Channel | Dir | Ports                 | Contents
//  --------+-----+-----------------------+------------------------------------------
//  s_axis  | in  | tvalid tready tdata   | tdata: data_byte, bit_count, unstuff
//          |     | tuser                 | tuser: req_type
//  m_axis  | out | tvalid tready tdata   | tdata: read_value, bits_delivered,
//          |     |                       |        fill_level, byte_dropped, overflow,
//          |     |                       |        skipping
//
// One word per cycle unless the output stalls, one result per word. The buffer update
// (barrel shift of the store plus fill compare) completes in the accept cycle.
// Reset is synchronous, active low: buffer empty, no skip search, no result held.
// A stalled output holds its word; input is taken while the result register is
// empty or drains in the same cycle.
`timescale 1ns / 1ps
`include "msb_bit_reader_with_unstuffing_defines.svh"
module msb_bit_reader_with_unstuffing #(
    parameter int STORE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] data_byte, [13:8] bit_count,
                                         // [14] unstuff, [15] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // [31:0] read_value, [37:32] bits_delivered,
                                         // [44:38] fill_level, [45] byte_dropped,
                                         // [46] overflow, [47] skipping
);
    import msbr_pkg::*;

    localparam int FILL_W = $clog2(STORE_BITS + 1);

    // Bit buffer, right aligned; bits above the fill count stay zero
    logic [STORE_BITS-1:0] r_store;
    logic [STORE_BITS-1:0] n_store;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    t_ctrl                 r_ctrl;
    t_ctrl                 n_ctrl;
    t_item                 item;
    t_result               step_res;
    t_result               out_res;
    logic                  accept;
    logic                  skip_start;

    // Unpack the incoming word
    assign item.req_type  = t_req'(i_s_axis_tuser);
    assign item.data_byte = i_s_axis_tdata[7:0];
    assign item.bit_count = i_s_axis_tdata[13:8];
    assign item.unstuff   = i_s_axis_tdata[14];

    assign accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign skip_start = accept && (item.req_type == REQ_SKIP);

    msbr_datapath #(
        .STORE_BITS(STORE_BITS),
        .FILL_W    (FILL_W)
    ) u_datapath (
        .i_item (item),
        .i_store(r_store),
        .i_fill (r_fill),
        .i_ctrl (r_ctrl),
        .o_store(n_store),
        .o_fill (n_fill),
        .o_ctrl (n_ctrl),
        .o_res  (step_res)
    );

    // Advance the buffer state only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_fill  <= '0;
            r_ctrl  <= '0;
        end else if (accept) begin
            r_store <= n_store;
            r_fill  <= n_fill;
            r_ctrl  <= n_ctrl;
        end
    end

    msbr_out_reg u_out_reg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .i_res  (step_res),
        .o_ready(o_s_axis_tready),
        .o_valid(o_m_axis_tvalid),
        .o_res  (out_res),
        .i_ready(i_m_axis_tready)
    );

    assign o_m_axis_tdata = out_res;

    // The fill count never passes the store size
    `MSBR_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(STORE_BITS))
    // Bits above the fill count are always clear
    `MSBR_ASSERT(a_store_clean, i_clk, i_rst_n, (r_store >> r_fill) == '0)
    // A skip empties the buffer and starts the search
    `MSBR_ASSERT_NEXT(a_skip_clears, i_clk, i_rst_n, skip_start, r_fill == '0 && r_ctrl.skip_active)
    // Every accepted word yields a result in the next cycle
    `MSBR_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, o_m_axis_tvalid)

endmodule

[tb/sv/tb_msb_bit_reader_with_unstuffing.sv]
// Self-checking testbench for the MSB-first bit reader with byte unstuffing.
// Runs a directed table and then a long random stream against a predictor of the
// bit buffer. Depends on msbr_pkg and the msb_bit_reader_with_unstuffing RTL.
`timescale 1ns / 1ps
module tb_msb_bit_reader_with_unstuffing;
    import msbr_pkg::*;

    localparam int         STORE_BITS   = 64;
    localparam int         RANDOM_WORDS = 1775;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;
    // Request code that the block decodes as a no-op
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    // Request mix of one random segment
    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_mix;

    // One row of the directed table; want is used only where typed is set
    typedef struct {
        logic [1:0] kind;
        logic [7:0] octet;
        logic [5:0] count;
        logic       unstuff;
        bit         typed;
        t_result    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;   // [7:0] data_byte, [13:8] bit_count,
                                        // [14] unstuff, [15] zero
    logic [1:0]  i_s_axis_tuser = '0;   // [1:0] req_type
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // [31:0] read_value, [37:32] bits_delivered,
                                        // [44:38] fill_level, [45] byte_dropped,
                                        // [46] overflow, [47] skipping

    // Predictor state: right-aligned store, fill count, stuffing history, skip search
    logic [127:0] buf_bits;
    int           buf_fill;
    logic [7:0]   prior_octet;
    logic         hunt_on;
    logic [7:0]   hunt_byte;

    t_result      pending_results[$];
    t_row         dir_rows[$];
    bit           no_idle = 1'b0;
    int           cycle_count = 0;
    int           n_fail = 0;
    int           n_words = 0;
    int           n_results = 0;
    int           n_push = 0;
    int           n_read = 0;
    int           n_skip = 0;
    int           n_unused = 0;
    int           n_overflow = 0;
    int           n_stuffed = 0;
    int           n_short = 0;

    msb_bit_reader_with_unstuffing #(
        .STORE_BITS(STORE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [127:0] low_ones(int k);
        if (k >= 128)
            return '1;
        return (128'd1 << k) - 128'd1;
    endfunction

    // Advance the predicted buffer by one request and return the word it yields
    function automatic t_result bitbuf_predict(logic [1:0] kind, logic [7:0] octet,
                                               logic [5:0] count_in, logic unstuff);
        t_result      res;
        logic [127:0] picked;
        logic         take;
        int           count;
        res    = '0;
        picked = '0;
        take   = 1'b1;
        // Clamp oversized reads to a full word
        count  = (count_in > READ_MAX) ? int'(READ_MAX) : int'(count_in);
        if (kind == REQ_PUSH) begin
            // While hunting, only the target byte ends the search and gets through
            if (hunt_on) begin
                if (octet == hunt_byte)
                    hunt_on = 1'b0;
                else
                    take = 1'b0;
            end
            if (!take) begin
                res.byte_dropped = 1'b1;
            end else if (unstuff && prior_octet == STUFF_MARK && octet == STUFF_ZERO) begin
                // Stuffed zero wins over a full buffer
                res.byte_dropped = 1'b1;
                prior_octet      = STUFF_ZERO;
                n_stuffed++;
            end else if (buf_fill + BYTE_BITS > STORE_BITS) begin
                res.byte_dropped = 1'b1;
                res.overflow     = 1'b1;
                n_overflow++;
            end else begin
                buf_bits    = (buf_bits << BYTE_BITS) | 128'(octet);
                buf_fill   += BYTE_BITS;
                prior_octet = octet;
            end
        end else if (kind == REQ_READ) begin
            if (count <= buf_fill) begin
                picked   = (buf_bits >> (buf_fill - count)) & low_ones(count);
                buf_fill = buf_fill - count;
                buf_bits = buf_bits & low_ones(buf_fill);
                res.bits_delivered = 6'(count);
            end else begin
                // Short read: hand out what is held, padded with zeros on the right
                picked   = (buf_bits & low_ones(buf_fill)) << (count - buf_fill);
                res.bits_delivered = 6'(buf_fill);
                buf_bits = '0;
                buf_fill = 0;
                n_short++;
            end
            res.read_value = picked[31:0];
        end else if (kind == REQ_SKIP) begin
            buf_bits  = '0;
            buf_fill  = 0;
            hunt_on   = 1'b1;
            hunt_byte = octet;
        end
        res.fill_level = 7'(buf_fill);
        res.skipping   = hunt_on;
        return res;
    endfunction

    function automatic t_result res_of(logic [31:0] value, int delivered, int fill,
                                       int dropped, int over, int skip);
        t_result r;
        r.read_value     = value;
        r.bits_delivered = 6'(delivered);
        r.fill_level     = 7'(fill);
        r.byte_dropped   = (dropped != 0);
        r.overflow       = (over != 0);
        r.skipping       = (skip != 0);
        return r;
    endfunction

    function automatic t_row stim(logic [1:0] kind, logic [7:0] octet, logic [5:0] count,
                                  logic unstuff, int typed, t_result want);
        t_row r;
        r.kind    = kind;
        r.octet   = octet;
        r.count   = count;
        r.unstuff = unstuff;
        r.typed   = (typed != 0);
        r.want    = want;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Present one word, hold it until accepted, then queue its expected result.
    // Valid is lowered only when a gap follows, so it never toggles within one step.
    task automatic send_word(logic [1:0] kind, logic [7:0] octet, logic [5:0] count,
                             logic unstuff, bit typed, t_result want);
        int      gap;
        t_result predicted;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, unstuff, count, octet};
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = bitbuf_predict(kind, octet, count, unstuff);
        pending_results.push_back(typed ? want : predicted);
        n_words++;
        case (kind)
            REQ_PUSH: n_push++;
            REQ_READ: n_read++;
            REQ_SKIP: n_skip++;
            default:  n_unused++;
        endcase
    endtask

    // Output side: stall for a random number of cycles before taking each word
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_rst_n));
        end
    end

    // Compare every word taken from the output with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (pending_results.size() == 0) begin
                $error("result word 0x%0h arrived with nothing expected", got);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                check_field("read_value", want.read_value, got.read_value);
                check_field("bits_delivered", 32'(want.bits_delivered),
                            32'(got.bits_delivered));
                check_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
                check_field("byte_dropped", 32'(want.byte_dropped), 32'(got.byte_dropped));
                check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                check_field("skipping", 32'(want.skipping), 32'(got.skipping));
            end
        end
    end

    initial begin
        t_mix       mix;
        int         seg_left;
        int         roll;
        int         push_cut;
        int         read_cut;
        logic [1:0] kind;
        logic [7:0] octet;
        logic [5:0] count;
        logic       unstuff;

        buf_bits    = '0;
        buf_fill    = 0;
        prior_octet = '0;
        hunt_on     = 1'b0;
        hunt_byte   = '0;

        // Directed table: stuffing, overflow, oversized and short reads, skip search
        dir_rows.push_back(stim(REQ_READ, 8'h00, 6'd32, 1'b0, 1, res_of(0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(stim(REQ_PUSH, 8'hFF, 6'd0, 1'b1, 1, res_of(0, 0, 8, 0, 0, 0)));
        dir_rows.push_back(stim(REQ_PUSH, 8'h00, 6'd0, 1'b1, 1, res_of(0, 0, 8, 1, 0, 0)));
        // Zero right after a stuffed zero is plain data
        dir_rows.push_back(stim(REQ_PUSH, 8'h00, 6'd0, 1'b1, 1, res_of(0, 0, 16, 0, 0, 0)));
        dir_rows.push_back(stim(REQ_PUSH, 8'hFF, 6'd0, 1'b0, 0, '0));
        dir_rows.push_back(stim(REQ_PUSH, 8'h00, 6'd0, 1'b0, 0, '0));
        dir_rows.push_back(stim(REQ_PUSH, 8'hA5, 6'd0, 1'b1, 0, '0));
        dir_rows.push_back(stim(REQ_PUSH, 8'h5A, 6'd0, 1'b1, 0, '0));
        dir_rows.push_back(stim(REQ_PUSH, 8'h80, 6'd0, 1'b1, 0, '0));
        dir_rows.push_back(stim(REQ_PUSH, 8'hFF, 6'd0, 1'b1, 0, '0));
        // Buffer full: stuffed zero reports as stuffing, the next byte as overflow
        dir_rows.push_back(stim(REQ_PUSH, 8'h00, 6'd0, 1'b1, 1, res_of(0, 0, 64, 1, 0, 0)));
        dir_rows.push_back(stim(REQ_PUSH, 8'h7E, 6'd0, 1'b1, 1, res_of(0, 0, 64, 1, 1, 0)));
        dir_rows.push_back(stim(REQ_READ, 8'h00, 6'd0, 1'b0, 1, res_of(0, 0, 64, 0, 0, 0)));
        dir_rows.push_back(stim(REQ_READ, 8'h00, 6'd63, 1'b0, 0, '0));
        dir_rows.push_back(stim(REQ_READ, 8'h00, 6'd33, 1'b0, 0, '0));
        dir_rows.push_back(stim(REQ_PUSH, 8'hC3, 6'd0, 1'b0, 0, '0));
        dir_rows.push_back(stim(REQ_READ, 8'h00, 6'd13, 1'b0, 1,
                                res_of(32'h1860, 8, 0, 0, 0, 0)));
        dir_rows.push_back(stim(REQ_PUSH, 8'h3C, 6'd0, 1'b0, 0, '0));
        dir_rows.push_back(stim(REQ_SKIP, 8'h42, 6'd0, 1'b0, 1, res_of(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(stim(REQ_PUSH, 8'h41, 6'd0, 1'b1, 1, res_of(0, 0, 0, 1, 0, 1)));
        dir_rows.push_back(stim(REQ_READ, 8'h00, 6'd8, 1'b0, 1, res_of(0, 0, 0, 0, 0, 1)));
        // A second skip restarts the search with the new target
        dir_rows.push_back(stim(REQ_SKIP, 8'h99, 6'd0, 1'b0, 1, res_of(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(stim(REQ_PUSH, 8'h42, 6'd0, 1'b1, 1, res_of(0, 0, 0, 1, 0, 1)));
        dir_rows.push_back(stim(REQ_PUSH, 8'h99, 6'd0, 1'b1, 1, res_of(0, 0, 8, 0, 0, 0)));
        dir_rows.push_back(stim(REQ_UNUSED, 8'hFF, 6'd63, 1'b1, 1,
                                res_of(0, 0, 8, 0, 0, 0)));
        dir_rows.push_back(stim(REQ_READ, 8'h00, 6'd1, 1'b0, 0, '0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_word(dir_rows[r].kind, dir_rows[r].octet, dir_rows[r].count,
                      dir_rows[r].unstuff, dir_rows[r].typed, dir_rows[r].want);

        // Random part in segments that lean toward filling, draining or a balance,
        // some of them without any idle cycles on either side
        seg_left = 0;
        mix      = MIX_BALANCED;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                mix      = t_mix'($urandom_range(0, 2));
                no_idle  = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            case (mix)
                MIX_FILL: begin
                    push_cut = 80;
                    read_cut = 95;
                end
                MIX_DRAIN: begin
                    push_cut = 25;
                    read_cut = 90;
                end
                default: begin
                    push_cut = 50;
                    read_cut = 90;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < push_cut)
                kind = REQ_PUSH;
            else if (roll < read_cut)
                kind = REQ_READ;
            else if (roll < 97)
                kind = REQ_SKIP;
            else
                kind = REQ_UNUSED;
            // Lean on marker and zero bytes so stuffing pairs turn up often
            roll = $urandom_range(0, 99);
            if (roll < 25)
                octet = STUFF_MARK;
            else if (roll < 45)
                octet = STUFF_ZERO;
            else
                octet = 8'($urandom_range(0, 255));
            // Let a search end after a few pushes
            if (kind == REQ_PUSH && hunt_on && $urandom_range(0, 4) == 0)
                octet = hunt_byte;
            count   = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 32))
                                                  : 6'($urandom_range(33, 63));
            unstuff = ($urandom_range(0, 3) != 0);
            send_word(kind, octet, count, unstuff, 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain, then give the output a few more cycles to show any stray word
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words: %0d pushes, %0d reads, %0d skips, %0d unused codes.",
                 n_words, n_push, n_read, n_skip, n_unused);
        $display("Checked %0d results; %0d overflow drops, %0d stuffed zeros, %0d short reads.",
                 n_results, n_overflow, n_stuffed, n_short);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/msbr_pkg.sv
rtl/msbr_datapath.sv
rtl/msbr_out_reg.sv
rtl/msb_bit_reader_with_unstuffing.sv
tb/sv/tb_msb_bit_reader_with_unstuffing.sv
